[design/dwlcd_pkg.sv]
// ----------------------------------------------------------------------------
// dwlcd_pkg
// Shared types, constants and helpers for the dirty-window LCD bus writer.
// ----------------------------------------------------------------------------
package dwlcd_pkg;

  // Bus and geometry constants.
  localparam int unsigned BusWidth     = 16;
  localparam int unsigned MaxDimension = 1024;
  localparam int unsigned DimW         = 11;  // width of a screen dimension register
  localparam int unsigned LineW        = 10;  // width of a clamped line or column index
  localparam int unsigned StateW       = 12;  // width of the dirty line markers
  localparam int unsigned CountW       = 21;  // width of the reported pixel count
  localparam int unsigned ByteBits     = 8;

  // Register indexes of the configuration port.
  localparam logic RegScreenWidth  = 1'b0;
  localparam logic RegScreenHeight = 1'b1;

  // Queue between the front and back parts.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Panel commands.
  localparam logic [BusWidth-1:0] CmdColumn   = BusWidth'(8'h2A);
  localparam logic [BusWidth-1:0] CmdPage     = BusWidth'(8'h2B);
  localparam logic [BusWidth-1:0] CmdMemWrite = BusWidth'(8'h2C);
  localparam logic [BusWidth-1:0] ByteMask    = BusWidth'(8'hFF);

  // Steps of the window sequence emitted for a flush.
  localparam int unsigned StepW = 4;
  typedef enum logic [StepW-1:0] {
    STEP_COL_CMD     = 4'd0,
    STEP_COL_ST_HI   = 4'd1,
    STEP_COL_ST_LO   = 4'd2,
    STEP_COL_END_HI  = 4'd3,
    STEP_COL_END_LO  = 4'd4,
    STEP_PAGE_CMD    = 4'd5,
    STEP_PG_ST_HI    = 4'd6,
    STEP_PG_ST_LO    = 4'd7,
    STEP_PG_END_HI   = 4'd8,
    STEP_PG_END_LO   = 4'd9,
    STEP_MEM_WRITE   = 4'd10
  } step_e;

  // Input item kinds.
  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_DATA  = 2'd2,
    OP_CMD   = 2'd3
  } op_e;

  typedef enum logic {
    KIND_WORD  = 1'b0,
    KIND_FLUSH = 1'b1
  } entry_kind_e;

  // One queued job for the back part.
  typedef struct packed {
    entry_kind_e         kind;
    logic                dc;
    logic [BusWidth-1:0] word;
    logic [LineW-1:0]    first_line;
    logic [LineW-1:0]    last_line;
  } queue_entry_t;

  // Effective dimension: zero counts as one, large values saturate.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] value);
    logic [DimW-1:0] result;
    if (value == '0) begin
      result = DimW'(1);
    end else if (value > DimW'(MaxDimension)) begin
      result = DimW'(MaxDimension);
    end else begin
      result = value;
    end
    return result;
  endfunction

endpackage

[design/dwlcd_front.sv]
// ----------------------------------------------------------------------------
// dwlcd_front
// Accepts items, tracks the dirty line range and queues bus jobs.
// ----------------------------------------------------------------------------
module dwlcd_front
  import dwlcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DimW-1:0]     eff_height_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  op_e                 opcode_i,
  input  logic [LineW-1:0]    mark_line_i,
  input  logic [DimW-1:0]     mark_height_i,
  input  logic                full_screen_i,
  input  logic [BusWidth-1:0] word_value_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output queue_entry_t        entry_o
);

  logic [StateW-1:0] dirty_first_q, dirty_first_d;
  logic [StateW-1:0] dirty_last_q, dirty_last_d;
  logic              in_fire;
  logic [LineW-1:0]  mark_y;
  logic [DimW-1:0]   mark_n;
  logic [StateW-1:0] mark_end;
  logic [StateW-1:0] h_last;
  logic              range_bad;
  logic [LineW-1:0]  flush_first;
  logic [LineW-1:0]  flush_last;

  assign in_ready_o = !queue_full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign h_last     = StateW'(eff_height_i) - StateW'(1);

  // A full-screen mark covers lines 0 to height-1; the end wraps modulo 4096.
  always_comb begin
    mark_y   = full_screen_i ? '0 : mark_line_i;
    mark_n   = full_screen_i ? eff_height_i : mark_height_i;
    mark_end = StateW'(mark_y) + StateW'(mark_n) - StateW'(1);
  end

  // An inverted or oversized range falls back to the whole screen.
  always_comb begin
    range_bad = (dirty_first_q > dirty_last_q) || (dirty_first_q > h_last) ||
                (dirty_last_q > h_last);
    flush_first = range_bad ? '0 : dirty_first_q[LineW-1:0];
    flush_last  = range_bad ? h_last[LineW-1:0] : dirty_last_q[LineW-1:0];
  end

  always_comb begin
    dirty_first_d = dirty_first_q;
    dirty_last_d  = dirty_last_q;
    if (in_fire) begin
      case (opcode_i)
        OP_MARK: begin
          if (StateW'(mark_y) < dirty_first_q) begin
            dirty_first_d = StateW'(mark_y);
          end
          if (mark_end > dirty_last_q) begin
            dirty_last_d = mark_end;
          end
        end
        OP_FLUSH: begin
          dirty_first_d = h_last;
          dirty_last_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    push_o             = in_fire && (opcode_i != OP_MARK);
    entry_o.kind       = (opcode_i == OP_FLUSH) ? KIND_FLUSH : KIND_WORD;
    entry_o.dc         = (opcode_i == OP_DATA);
    entry_o.word       = word_value_i;
    entry_o.first_line = flush_first;
    entry_o.last_line  = flush_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_first_q <= '0;
      dirty_last_q  <= '0;
    end else begin
      dirty_first_q <= dirty_first_d;
      dirty_last_q  <= dirty_last_d;
    end
  end

`ifndef SYNTHESIS
  a_flush_resets_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (opcode_i == OP_FLUSH) |=> dirty_last_q == '0)
    else $error("dirty_last not cleared after flush");

  a_mark_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (opcode_i != OP_MARK) && !queue_full_i)
    else $error("queue push from a mark item or into a full queue");
`endif

endmodule

[design/dwlcd_fifo.sv]
// ----------------------------------------------------------------------------
// dwlcd_fifo
// Short queue of bus jobs between the front and back parts.
// ----------------------------------------------------------------------------
module dwlcd_fifo
  import dwlcd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  queue_entry_t entry_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output queue_entry_t head_o
);

  queue_entry_t     mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= QPtrW'((QCntW'(wr_ptr_q) + QCntW'(1)) % QCntW'(QueueDepth));
      end
      if (pop_i) begin
        rd_ptr_q <= QPtrW'((QCntW'(rd_ptr_q) + QCntW'(1)) % QCntW'(QueueDepth));
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");
`endif

endmodule

[design/dwlcd_back.sv]
// ----------------------------------------------------------------------------
// dwlcd_back
// Turns queued jobs into bus words and holds the output register.
// ----------------------------------------------------------------------------
module dwlcd_back
  import dwlcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DimW-1:0]     eff_width_i,
  input  logic                head_valid_i,
  input  queue_entry_t        head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_dc_o,
  output logic [BusWidth-1:0] out_word_o,
  output logic [BusWidth-1:0] out_toggle_o,
  output logic                out_last_o,
  output logic [CountW-1:0]   out_count_o
);

  step_e               step_q, step_d;
  logic [BusWidth-1:0] prev_word_q;
  logic                out_valid_q;
  logic                emit;
  logic                nxt_dc;
  logic [BusWidth-1:0] nxt_word;
  logic                nxt_last;
  logic [CountW-1:0]   nxt_count;
  logic [DimW-1:0]     col_end;
  logic [DimW-1:0]     span;
  logic [2*DimW-1:0]   product;

  assign emit    = head_valid_i && (!out_valid_q || out_ready_i);
  assign col_end = eff_width_i - DimW'(1);
  assign span    = DimW'(head_i.last_line) - DimW'(head_i.first_line) + DimW'(1);
  assign product = span * eff_width_i;

  always_comb begin
    nxt_dc    = 1'b1;
    nxt_word  = '0;
    nxt_last  = 1'b0;
    nxt_count = '0;
    step_d    = step_q;
    pop_o     = 1'b0;
    if (head_i.kind == KIND_WORD) begin
      nxt_dc   = head_i.dc;
      nxt_word = head_i.word;
      nxt_last = 1'b1;
      pop_o    = emit;
    end else begin
      case (step_q)
        STEP_COL_CMD: begin
          nxt_dc   = 1'b0;
          nxt_word = CmdColumn;
        end
        STEP_COL_ST_HI, STEP_COL_ST_LO: nxt_word = '0;
        STEP_COL_END_HI: nxt_word = BusWidth'(col_end >> ByteBits);
        STEP_COL_END_LO: nxt_word = BusWidth'(col_end) & ByteMask;
        STEP_PAGE_CMD: begin
          nxt_dc   = 1'b0;
          nxt_word = CmdPage;
        end
        STEP_PG_ST_HI:  nxt_word = BusWidth'(head_i.first_line >> ByteBits);
        STEP_PG_ST_LO:  nxt_word = BusWidth'(head_i.first_line) & ByteMask;
        STEP_PG_END_HI: nxt_word = BusWidth'(head_i.last_line >> ByteBits);
        STEP_PG_END_LO: nxt_word = BusWidth'(head_i.last_line) & ByteMask;
        STEP_MEM_WRITE: begin
          nxt_dc    = 1'b0;
          nxt_word  = CmdMemWrite;
          nxt_last  = 1'b1;
          nxt_count = product[CountW-1:0];
        end
        default: begin
        end
      endcase
      if (emit) begin
        if (step_q == STEP_MEM_WRITE) begin
          step_d = STEP_COL_CMD;
          pop_o  = 1'b1;
        end else begin
          step_d = step_e'(step_q + StepW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_COL_CMD;
      out_valid_q <= 1'b0;
      prev_word_q <= '0;
    end else begin
      step_q <= step_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        prev_word_q <= nxt_word;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_dc_o     <= nxt_dc;
      out_word_o   <= nxt_word;
      out_toggle_o <= nxt_word ^ prev_word_q;
      out_last_o   <= nxt_last;
      out_count_o  <= nxt_count;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_step_only_in_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != STEP_COL_CMD |-> head_valid_i && head_i.kind == KIND_FLUSH)
    else $error("window sequence running without a flush job");

  a_memwrite_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && head_i.kind == KIND_FLUSH && step_q == STEP_MEM_WRITE |=>
      out_last_o && !out_dc_o)
    else $error("memory write command not marked as last");

  a_toggle_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_toggle_o == (out_word_o ^ $past(prev_word_q)))
    else $error("toggle mask does not match the previous word");
`endif

endmodule

[design/dirty_window_lcd_bus_writer_core.sv]
// ----------------------------------------------------------------------------
// dirty_window_lcd_bus_writer_core
// 16-bit 8080 LCD bus writer with dirty line tracking and window setup.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Contents
// s_axis    in         tuser: opcode; tdata: mark_line, mark_height,
//                      full_screen, word_value
// m_axis    out        tuser: dc; tlast: last; tdata: bus_word, toggle_mask,
//                      pixel_count
// cfg       in         write enable, register index, 11-bit data
//
// Data and command items produce one transfer each, so pixel words pass at one
// transfer per clock unless the output stalls. A flush emits eleven words from
// the back sequencer, while the front keeps accepting items into a four-entry
// queue. Mark items are absorbed by the front and produce no transfer.
// Reset is asynchronous and active low; it clears the markers, the queue, the
// sequencer and the previous-word register, and loads the screen size
// registers with 480 by 320. Stalls on the output hold the output register and
// back up the queue; the input stalls only when the queue is full.
//
module dirty_window_lcd_bus_writer_core
  import dwlcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // mark_line[9:0], mark_height[20:10],
                                      // full_screen[21], word_value[37:22], zero
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // bus_word[15:0], toggle_mask[31:16],
                                      // pixel_count[52:32], zero
  output logic        m_axis_tuser,   // dc[0]
  output logic        m_axis_tlast
);

  logic [DimW-1:0]     screen_width_q;
  logic [DimW-1:0]     screen_height_q;
  logic [DimW-1:0]     eff_width;
  logic [DimW-1:0]     eff_height;
  logic                queue_full;
  logic                queue_push;
  queue_entry_t        queue_in;
  logic                queue_valid;
  logic                queue_pop;
  queue_entry_t        queue_head;
  logic [BusWidth-1:0] out_word;
  logic [BusWidth-1:0] out_toggle;
  logic [CountW-1:0]   out_count;

  // Screen size registers; values are clamped to a usable size where read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= DimW'(480);
      screen_height_q <= DimW'(320);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegScreenWidth:  screen_width_q  <= cfg_data_i;
        RegScreenHeight: screen_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign eff_width  = eff_dim(screen_width_q);
  assign eff_height = eff_dim(screen_height_q);

  // Front: accepts items, keeps the dirty range and snapshots it on a flush.
  dwlcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eff_height_i  (eff_height),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .opcode_i      (op_e'(s_axis_tuser)),
    .mark_line_i   (s_axis_tdata[9:0]),
    .mark_height_i (s_axis_tdata[20:10]),
    .full_screen_i (s_axis_tdata[21]),
    .word_value_i  (s_axis_tdata[37:22]),
    .queue_full_i  (queue_full),
    .push_o        (queue_push),
    .entry_o       (queue_in)
  );

  // Queue of pending bus jobs.
  dwlcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .entry_i (queue_in),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .head_o  (queue_head)
  );

  // Back: sequences the window commands and drives the output register.
  dwlcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_width_i  (eff_width),
    .head_valid_i (queue_valid),
    .head_i       (queue_head),
    .pop_o        (queue_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_dc_o     (m_axis_tuser),
    .out_word_o   (out_word),
    .out_toggle_o (out_toggle),
    .out_last_o   (m_axis_tlast),
    .out_count_o  (out_count)
  );

  assign m_axis_tdata = {3'b000, out_count, out_toggle, out_word};

endmodule
